// ===== rtl/ase_pkg.sv =====
`timescale 1ns / 1ps

package ase_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LIMIT_W   = 7;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int CAP_RESET = 64;

    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

    localparam int RQ_DEPTH  = 4;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQL_W     = $clog2(RQ_DEPTH + 1);
    localparam int SUM_W     = RQL_W + 1;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_DISPLAY = 3'd2,
        OP_PEEP    = 3'd3,
        OP_CHANGE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_INVALID  = 2'd3
    } st_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  data;
        logic [POS_W-1:0]          position;
    } cmd_t;

    typedef struct packed {
        st_t                       status;
        logic signed [DATA_W-1:0]  data;
        logic [LIMIT_W-1:0]        entry_count;
        logic                      last;
    } res_t;

endpackage

// ===== rtl/ase_front.sv =====
`timescale 1ns / 1ps

module ase_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    operation,
    input  logic signed [ase_pkg::DATA_W-1:0] data_in,
    input  logic [ase_pkg::POS_W-1:0]     position,
    output logic                          cmd_valid,
    output ase_pkg::cmd_t                 cmd,
    input  logic                          cmd_ready
);
    import ase_pkg::*;

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] level_reg, level_next;
    logic                op_known;
    logic                wr_en;
    logic                rd_en;
    cmd_t                incoming;

    assign full      = (level_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cmd_valid = (level_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    // drop codes with no operation
    assign op_known = (operation == OP_PUSH) || (operation == OP_POP)
                   || (operation == OP_DISPLAY) || (operation == OP_PEEP)
                   || (operation == OP_CHANGE);

    always_comb
    begin
        incoming.op       = op_t'(operation);
        incoming.data     = data_in;
        incoming.position = position;
        wr_en       = push && !full && op_known;
        rd_en       = cmd_valid && cmd_ready;
        wr_ptr_next = wr_en ? wr_ptr_reg + CQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + CQ_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + CQ_CNT_W'(wr_en) - CQ_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ===== rtl/ase_back.sv =====
`timescale 1ns / 1ps

module ase_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ase_pkg::LIMIT_W-1:0]   cap_limit,
    input  logic                          cmd_valid,
    input  ase_pkg::cmd_t                 cmd,
    output logic                          cmd_ready,
    input  logic [ase_pkg::RQL_W-1:0]     rq_level,
    output logic                          res_valid,
    output ase_pkg::res_t                 res
);
    import ase_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              r_valid_reg, r_valid_next;
    logic              r_use_mem_reg;
    res_t              r_res_reg;

    logic              room;
    logic              go;
    logic              stack_empty;
    logic              stack_full;
    logic              pos_bad;
    logic              disp_last;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              fire;
    logic              use_mem;
    res_t              meta;

    assign room = (SUM_W'(rq_level) + SUM_W'(r_valid_reg)) < SUM_W'(RQ_DEPTH);
    assign go   = cmd_valid && room;

    assign stack_empty = (count_reg == '0);
    assign stack_full  = (CMP_W'(count_reg) >= CMP_W'(cap_limit))
                      || (CMP_W'(count_reg) >= CMP_W'(DEPTH));
    assign pos_bad     = (cmd.position == '0)
                      || (CMP_W'(cmd.position) > CMP_W'(count_reg));
    assign disp_last   = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);
    assign waddr       = (cmd.op == OP_PUSH) ? ADDR_W'(count_reg)
                                             : ADDR_W'(cmd.position - POS_W'(1));

    always_comb
    begin
        count_next       = count_reg;
        idx_next         = idx_reg;
        we               = 1'b0;
        raddr            = idx_reg;
        fire             = 1'b0;
        use_mem          = 1'b0;
        cmd_ready        = 1'b0;
        meta.status      = ST_OK;
        meta.data        = '0;
        meta.last        = 1'b1;
        case (cmd.op)
            OP_PUSH:
            begin
                fire      = go;
                cmd_ready = go;
                if (stack_full)
                begin
                    meta.status = ST_OVERFLOW;
                end
                else
                begin
                    we         = go;
                    meta.data  = cmd.data;
                    count_next = go ? count_reg + CNT_W'(1) : count_reg;
                end
            end
            OP_POP:
            begin
                fire      = go;
                cmd_ready = go;
                if (stack_empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    use_mem    = 1'b1;
                    raddr      = ADDR_W'(count_reg - CNT_W'(1));
                    count_next = go ? count_reg - CNT_W'(1) : count_reg;
                end
            end
            OP_DISPLAY:
            begin
                fire = go;
                if (stack_empty)
                begin
                    meta.status = ST_EMPTY;
                    cmd_ready   = go;
                end
                else
                begin
                    use_mem   = 1'b1;
                    raddr     = idx_reg;
                    meta.last = disp_last;
                    cmd_ready = go && disp_last;
                    if (go)
                    begin
                        idx_next = disp_last ? '0 : idx_reg + ADDR_W'(1);
                    end
                end
            end
            OP_PEEP, OP_CHANGE:
            begin
                fire      = go;
                cmd_ready = go;
                if (stack_empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else if (pos_bad)
                begin
                    meta.status = ST_INVALID;
                end
                else if (cmd.op == OP_PEEP)
                begin
                    use_mem = 1'b1;
                    raddr   = ADDR_W'(cmd.position - POS_W'(1));
                end
                else
                begin
                    we        = go;
                    meta.data = cmd.data;
                end
            end
            default:
            begin
                cmd_ready = go;
            end
        endcase
        meta.entry_count = LIMIT_W'(count_next);
        r_valid_next     = fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_res_reg     <= meta;
        r_use_mem_reg <= use_mem;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= cmd.data;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        res = r_res_reg;
        if (r_use_mem_reg)
        begin
            res.data = rdata_reg;
        end
    end

    assign res_valid = r_valid_reg;

`ifndef SYNTH
    a_rq_room: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg |-> (rq_level < RQL_W'(RQ_DEPTH)))
        else $error("result written into a full result queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("stack count above depth");

    a_disp_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("display index past stack top");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cmd.op == OP_PUSH && !stack_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");
`endif

endmodule

// ===== rtl/ase_rq.sv =====
`timescale 1ns / 1ps

module ase_rq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      res_valid,
    input  ase_pkg::res_t             res,
    output logic [ase_pkg::RQL_W-1:0] rq_level,
    output logic                      empty,
    input  logic                      pop,
    output ase_pkg::res_t             head
);
    import ase_pkg::*;

    res_t                slot_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQL_W-1:0]    level_reg, level_next;
    logic                rd_en;

    assign empty    = (level_reg == '0);
    assign head     = slot_reg[rd_ptr_reg];
    assign rq_level = level_reg;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_valid ? wr_ptr_reg + RQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + RQ_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + RQL_W'(res_valid) - RQL_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== rtl/array_stack_engine.sv =====
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit words with a run-time capacity limit, queue-like on both
// sides. Items enter a two-entry command queue; while the result queue has room, the back
// end makes one memory access per cycle on a single 64-word array: one access each for push,
// pop, peep and change, one per stored word for display (one when empty), which holds later
// items in the command queue meanwhile. Each result is registered in the back end, then
// written into the four-entry result queue; the sustained rate is one item per cycle while
// results are popped, set by the single memory port and the result queue depth. Codes 5 to 7
// are accepted and dropped without a result. No clearing pass: stack entries are written before
// they can be read. Capacity resets to 64; write it only while idle (the block does not enforce it).

module array_stack_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ase_pkg::PADDR_W-1:0]           paddr,
    input  logic [ase_pkg::PDATA_W-1:0]           pwdata,
    output logic [ase_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  push,
    output logic                                  full,
    input  logic [2:0]                            operation,
    input  logic signed [ase_pkg::DATA_W-1:0]     data_in,
    input  logic [ase_pkg::POS_W-1:0]             position,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [1:0]                            status,
    output logic signed [ase_pkg::DATA_W-1:0]     data_out,
    output logic [ase_pkg::LIMIT_W-1:0]           entry_count,
    output logic                                  last_of_run
);
    import ase_pkg::*;

    logic [LIMIT_W-1:0] cap_limit_reg, cap_limit_next;
    logic               cap_sel;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;
    logic               res_valid;
    res_t               res;
    res_t               head;
    logic [RQL_W-1:0]   rq_level;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign prdata  = cap_sel ? PDATA_W'(cap_limit_reg) : '0;

    always_comb
    begin
        cap_limit_next = cap_limit_reg;
        if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_limit_reg <= LIMIT_W'(CAP_RESET);
        end
        else
        begin
            cap_limit_reg <= cap_limit_next;
        end
    end

    ase_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .data_in   (data_in),
        .position  (position),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    ase_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_limit (cap_limit_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .rq_level  (rq_level),
        .res_valid (res_valid),
        .res       (res)
    );

    ase_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .rq_level  (rq_level),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign status      = head.status;
    assign data_out    = head.data;
    assign entry_count = head.entry_count;
    assign last_of_run = head.last;

endmodule

// ===== test/tb_array_stack_engine.sv =====
`timescale 1ns / 1ps

module tb_array_stack_engine;

    import ase_pkg::*;

    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});

    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef enum logic [1:0] {
        MODE_RECV_HEAVY,
        MODE_SEND_HEAVY,
        MODE_NO_IDLE
    } idle_mode_t;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         pos;
        logic                     typed;
        res_t                     outcome;
    } stim_row_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] cap;
        logic [7:0]         items;
        logic [6:0]         push_pct;
        idle_mode_t         mode;
    } cap_phase_t;

    localparam stim_row_t DIRECTED_ROWS [26] = '{
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY,   32'h0,         7'd0, 1'b1}},
        '{OP_DISPLAY, 32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY,   32'h0,         7'd0, 1'b1}},
        '{OP_PEEP,    32'h0000_0000, 7'd1,   1'b1, '{ST_EMPTY,   32'h0,         7'd0, 1'b1}},
        '{OP_CHANGE,  32'h1234_5678, 7'd0,   1'b1, '{ST_EMPTY,   32'h0,         7'd0, 1'b1}},
        '{OP_PUSH,    32'h7FFF_FFFF, 7'd0,   1'b1, '{ST_OK,      32'h7FFF_FFFF, 7'd1, 1'b1}},
        '{OP_PUSH,    32'h8000_0000, 7'd127, 1'b1, '{ST_OK,      32'h8000_0000, 7'd2, 1'b1}},
        '{OP_PUSH,    32'hFFFF_FFFF, 7'd0,   1'b1, '{ST_OK,      32'hFFFF_FFFF, 7'd3, 1'b1}},
        '{OP_PUSH,    32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      32'h0,         7'd4, 1'b1}},
        '{OP_RSVD_5,  32'hFFFF_FFFF, 7'd127, 1'b0, '0},
        '{OP_RSVD_7,  32'h0000_0000, 7'd0,   1'b0, '0},
        '{OP_PEEP,    32'h0000_0000, 7'd0,   1'b1, '{ST_INVALID, 32'h0,         7'd4, 1'b1}},
        '{OP_PEEP,    32'h0000_0000, 7'd5,   1'b1, '{ST_INVALID, 32'h0,         7'd4, 1'b1}},
        '{OP_PEEP,    32'h0000_0000, 7'd127, 1'b1, '{ST_INVALID, 32'h0,         7'd4, 1'b1}},
        '{OP_PEEP,    32'h0000_0000, 7'd1,   1'b1, '{ST_OK,      32'h7FFF_FFFF, 7'd4, 1'b1}},
        '{OP_CHANGE,  32'h5A5A_5A5A, 7'd4,   1'b1, '{ST_OK,      32'h5A5A_5A5A, 7'd4, 1'b1}},
        '{OP_CHANGE,  32'h0000_007B, 7'd127, 1'b1, '{ST_INVALID, 32'h0,         7'd4, 1'b1}},
        '{OP_CHANGE,  32'h0000_004D, 7'd0,   1'b1, '{ST_INVALID, 32'h0,         7'd4, 1'b1}},
        '{OP_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, '0},
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      32'h5A5A_5A5A, 7'd3, 1'b1}},
        '{OP_RSVD_6,  32'hA5A5_A5A5, 7'd42,  1'b0, '0},
        '{OP_PEEP,    32'h0000_0000, 7'd3,   1'b1, '{ST_OK,      32'hFFFF_FFFF, 7'd3, 1'b1}},
        '{OP_DISPLAY, 32'h0000_0000, 7'd0,   1'b0, '0},
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      32'hFFFF_FFFF, 7'd2, 1'b1}},
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      32'h8000_0000, 7'd1, 1'b1}},
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_OK,      32'h7FFF_FFFF, 7'd0, 1'b1}},
        '{OP_POP,     32'h0000_0000, 7'd0,   1'b1, '{ST_EMPTY,   32'h0,         7'd0, 1'b1}}
    };

    localparam cap_phase_t CAP_PHASES [6] = '{
        '{7'd3,   8'd12, 7'd50, MODE_RECV_HEAVY},
        '{7'd0,   8'd6,  7'd50, MODE_RECV_HEAVY},
        '{7'd127, 8'd75, 7'd95, MODE_SEND_HEAVY},
        '{7'd10,  8'd20, 7'd40, MODE_SEND_HEAVY},
        '{7'd1,   8'd10, 7'd30, MODE_NO_IDLE},
        '{7'd64,  8'd20, 7'd55, MODE_NO_IDLE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      push;
    logic                      full;
    logic [2:0]                operation;
    logic signed [DATA_W-1:0]  data_in;
    logic [POS_W-1:0]          position;
    logic                      empty;
    logic                      pop;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  data_out;
    logic [LIMIT_W-1:0]        entry_count;
    logic                      last_of_run;

    logic signed [DATA_W-1:0]  stack_mem [DEPTH];
    int                        stack_depth = 0;
    logic [LIMIT_W-1:0]        cap_limit = LIMIT_W'(CAP_RESET);
    res_t                      pending_results [$];

    int err_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int overflows_seen = 0;
    int deepest_stack = 0;
    int longest_display = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    array_stack_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .data_in     (data_in),
        .position    (position),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .data_out    (data_out),
        .entry_count (entry_count),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: expected no result, got status %0d data %h count %0d last %b",
                         $time, status, data_out, entry_count, last_of_run);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (status === ST_OVERFLOW)
                    overflows_seen++;
                if (status !== want.status || data_out !== want.data ||
                    entry_count !== want.entry_count || last_of_run !== want.last)
                begin
                    err_count++;
                    $display("%0t: mismatch: expected status %0d data %h count %0d last %b",
                             $time, want.status, want.data, want.entry_count, want.last);
                    $display("%0t:           got      status %0d data %h count %0d last %b",
                             $time, status, data_out, entry_count, last_of_run);
                end
            end
        end
    end

    task automatic apply_stack_op(input logic [2:0] op, input logic signed [DATA_W-1:0] d,
                                  input logic [POS_W-1:0] p, input logic use_table,
                                  input res_t table_res);
        int   eff_cap;
        bit   single;
        res_t r;
        eff_cap = (cap_limit < DEPTH) ? int'(cap_limit) : DEPTH;
        single = 1'b1;
        r = '0;
        r.last = 1'b1;
        case (op)
            OP_PUSH:
                if (stack_depth >= eff_cap)
                    r.status = ST_OVERFLOW;
                else
                begin
                    stack_mem[stack_depth] = d;
                    stack_depth++;
                    r.data = d;
                end
            OP_POP:
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    stack_depth--;
                    r.data = stack_mem[stack_depth];
                end
            OP_DISPLAY:
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    single = 1'b0;
                    if (stack_depth > longest_display)
                        longest_display = stack_depth;
                    for (int i = 0; i < stack_depth; i++)
                    begin
                        r.data = stack_mem[i];
                        r.entry_count = LIMIT_W'(stack_depth);
                        r.last = (i == stack_depth - 1);
                        pending_results.push_back(r);
                    end
                end
            OP_PEEP, OP_CHANGE:
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else if (p == 0 || p > stack_depth)
                    r.status = ST_INVALID;
                else if (op == OP_PEEP)
                    r.data = stack_mem[p - 1];
                else
                begin
                    stack_mem[p - 1] = d;
                    r.data = d;
                end
            default:
                single = 1'b0;
        endcase
        if (single)
        begin
            r.entry_count = LIMIT_W'(stack_depth);
            pending_results.push_back(use_table ? table_res : r);
        end
        if (stack_depth > deepest_stack)
            deepest_stack = stack_depth;
    endtask

    task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] d,
                             input logic [POS_W-1:0] p, input logic use_table,
                             input res_t table_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push      <= 1'b1;
        operation <= op;
        data_in   <= d;
        position  <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_stack_op(op, d, p, use_table, table_res);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cap_limit = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[LIMIT_W-1:0] !== value)
        begin
            err_count++;
            $display("%0t: capacity readback mismatch: expected %0d, got %0d",
                     $time, value, prdata[LIMIT_W-1:0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            MODE_RECV_HEAVY:
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 52;
            end
            MODE_SEND_HEAVY:
            begin
                send_idle_pct  = 52;
                recv_stall_pct = 26;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        cap_phase_t               ph;
        logic [2:0]               op;
        logic signed [DATA_W-1:0] d;
        logic [POS_W-1:0]         p;
        int                       roll;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        push      = 1'b0;
        operation = OP_PUSH;
        data_in   = '0;
        position  = '0;
        set_idle_mode(MODE_RECV_HEAVY);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pos,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].outcome);

        foreach (CAP_PHASES[n])
        begin
            ph = CAP_PHASES[n];
            wait_drained();
            write_capacity(ph.cap);
            set_idle_mode(ph.mode);
            for (int k = 0; k < ph.items; k++)
            begin
                // hold the sender until every pending result is out
                if (k == ph.items / 2)
                    wait_drained();

                if ($urandom_range(99) < ph.push_pct)
                    op = OP_PUSH;
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 30)
                        op = OP_POP;
                    else if (roll < 42)
                        op = OP_DISPLAY;
                    else if (roll < 66)
                        op = OP_PEEP;
                    else if (roll < 95)
                        op = OP_CHANGE;
                    else
                        op = 3'($urandom_range(OP_RSVD_7, OP_RSVD_5));
                end

                roll = $urandom_range(99);
                if (roll < 3)
                    d = 32'sh7FFF_FFFF;
                else if (roll < 6)
                    d = 32'sh8000_0000;
                else if (roll < 8)
                    d = '0;
                else if (roll < 10)
                    d = '1;
                else
                    d = $urandom;

                roll = $urandom_range(99);
                if (stack_depth == 0 || roll >= 90)
                    p = POS_W'($urandom_range(127));
                else if (roll < 70)
                    p = POS_W'($urandom_range(stack_depth, 1));
                else if (roll < 80)
                    p = '0;
                else
                    p = POS_W'(stack_depth + 1);

                send_item(op, d, p, 1'b0, '0);
            end
        end

        wait_drained();

        $display("Coverage: %0d transactions sent, %0d results checked, %0d overflows",
                 items_sent, results_checked, overflows_seen);
        $display("          deepest stack %0d, longest display %0d, 6 capacity settings",
                 deepest_stack, longest_display);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ase_pkg.sv
rtl/ase_front.sv
rtl/ase_back.sv
rtl/ase_rq.sv
rtl/array_stack_engine.sv
test/tb_array_stack_engine.sv
